@@ rtl/prc_pkg.sv @@
// ----------------------------------------------------------------------------
// prc_pkg
// Shared widths, constants, register codes and types of the Prewitt compass
// gradient block.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int PIXEL_W            = 8;
  localparam int CFG_DATA_W         = 12;
  localparam int CFG_INDEX_W        = 1;
  localparam int ROW_W              = 12;
  localparam int MAX_WIDTH_DEFAULT  = 2048;
  localparam int LINE_WIDTH_RESET   = 640;
  localparam int FRAME_HEIGHT_RESET = 480;
  localparam int MIN_DIM            = 3;
  localparam int GRAD_MAX           = 255;
  localparam int NUM_DIRS           = 4;
  localparam int WIN_TAPS           = 9;
  // A kernel sum lies within +/-765, which needs eleven signed bits.
  localparam int SUM_W              = 11;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic signed [1:0]       coef_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // Compass kernels for 0, 45, 90 and 135 degrees, taps in raster order of
  // the window (top left first).
  localparam coef_t KERNEL [NUM_DIRS][WIN_TAPS] = '{
    '{ 2'sd1,  2'sd1,  2'sd1,  2'sd0,  2'sd0,  2'sd0, -2'sd1, -2'sd1, -2'sd1 },
    '{ 2'sd1,  2'sd0, -2'sd1,  2'sd1,  2'sd0, -2'sd1,  2'sd1,  2'sd0, -2'sd1 },
    '{ 2'sd1,  2'sd1,  2'sd0,  2'sd1,  2'sd0, -2'sd1,  2'sd0, -2'sd1, -2'sd1 },
    '{ 2'sd0,  2'sd1,  2'sd1, -2'sd1,  2'sd0,  2'sd1, -2'sd1, -2'sd1,  2'sd0 }
  };

  typedef struct packed {
    logic [WIN_TAPS-1:0][PIXEL_W-1:0] px;
  } window_t;

  typedef struct packed {
    logic interior;
    logic last;
  } win_flags_t;

endpackage

@@ rtl/prc_pixel_if.sv @@
// ----------------------------------------------------------------------------
// prc_pixel_if
// Valid/ready channel that carries one grey pixel per item.
// ----------------------------------------------------------------------------
interface prc_pixel_if;
  logic                         valid;
  logic                         ready;
  logic [prc_pkg::PIXEL_W-1:0]  pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

@@ rtl/prc_result_if.sv @@
// ----------------------------------------------------------------------------
// prc_result_if
// Valid/ready channel that carries one gradient result per item.
// ----------------------------------------------------------------------------
interface prc_result_if;
  logic                         valid;
  logic                         ready;
  logic [prc_pkg::PIXEL_W-1:0]  gradient;
  logic                         last_of_frame;

  modport source (output valid, output gradient, output last_of_frame, input ready);
  modport sink   (input valid, input gradient, input last_of_frame, output ready);
endinterface

@@ rtl/prc_window.sv @@
// ----------------------------------------------------------------------------
// prc_window
// Frame position counters, the two line stores and the 3x3 window registers.
// Presents one window per accepted pixel, registered.
// ----------------------------------------------------------------------------
module prc_window #(
  parameter int MAX_WIDTH = prc_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [prc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0]   cfg_data,
  prc_pixel_if.sink                        pixels,
  output logic                             win_valid,
  output prc_pkg::window_t                 win,
  output prc_pkg::win_flags_t              win_flags,
  input  logic                             win_ready
);

  localparam int COL_W = $clog2(MAX_WIDTH);

  function automatic logic [COL_W-1:0] width_last_of(input logic [prc_pkg::CFG_DATA_W-1:0] w);
    int v;
    v = int'(w);
    if (v < prc_pkg::MIN_DIM) v = prc_pkg::MIN_DIM;
    if (v > MAX_WIDTH) v = MAX_WIDTH;
    return COL_W'(v - 1);
  endfunction

  function automatic logic [prc_pkg::ROW_W-1:0] height_last_of(
    input logic [prc_pkg::CFG_DATA_W-1:0] h);
    int v;
    v = int'(h);
    if (v < prc_pkg::MIN_DIM) v = prc_pkg::MIN_DIM;
    return prc_pkg::ROW_W'(v - 1);
  endfunction

  logic [COL_W-1:0]           width_last;
  logic [prc_pkg::ROW_W-1:0]  height_last;
  logic [COL_W-1:0]           col;
  logic [prc_pkg::ROW_W-1:0]  row;
  logic                       col_wrap;
  logic                       row_wrap;
  logic                       accept;
  logic                       s1_adv;

  logic                           s1_valid;
  logic [prc_pkg::PIXEL_W-1:0]    s1_pixel;
  logic [COL_W-1:0]               s1_col;
  prc_pkg::win_flags_t            s1_flags;
  logic [prc_pkg::PIXEL_W-1:0]    upper_rd;
  logic [prc_pkg::PIXEL_W-1:0]    middle_rd;
  logic [prc_pkg::PIXEL_W-1:0]    win_regs [6];

  logic [prc_pkg::PIXEL_W-1:0]    upper_mem  [MAX_WIDTH];
  logic [prc_pkg::PIXEL_W-1:0]    middle_mem [MAX_WIDTH];

  assign s1_adv       = s1_valid && win_ready;
  assign pixels.ready = !s1_valid || win_ready;
  assign accept       = pixels.valid && pixels.ready;
  assign col_wrap     = (col == width_last);
  assign row_wrap     = (row == height_last);

  // Frame position and the clamped frame geometry.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= width_last_of(prc_pkg::CFG_DATA_W'(prc_pkg::LINE_WIDTH_RESET));
      height_last <= height_last_of(prc_pkg::CFG_DATA_W'(prc_pkg::FRAME_HEIGHT_RESET));
      col         <= '0;
      row         <= '0;
    end else if (cfg_we) begin
      unique case (prc_pkg::cfg_reg_t'(cfg_index))
        prc_pkg::REG_LINE_WIDTH: begin
          width_last <= width_last_of(cfg_data);
          col        <= '0;
          row        <= '0;
        end
        prc_pkg::REG_FRAME_HEIGHT: begin
          height_last <= height_last_of(cfg_data);
          col         <= '0;
          row         <= '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (col_wrap) begin
        col <= '0;
        row <= row_wrap ? '0 : row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pixel          <= pixels.pixel;
      s1_col            <= col;
      s1_flags.interior <= (row[prc_pkg::ROW_W-1:1] != '0) && (col[COL_W-1:1] != '0);
      s1_flags.last     <= col_wrap && row_wrap;
    end
  end

  // Line stores: read at the column of the incoming pixel, written back when
  // that pixel leaves the window stage. The two never meet at one address
  // because a row is at least three pixels long.
  always_ff @(posedge clk) begin
    if (accept) begin
      upper_rd  <= upper_mem[col];
      middle_rd <= middle_mem[col];
    end
    if (s1_adv) begin
      upper_mem[s1_col]  <= middle_rd;
      middle_mem[s1_col] <= s1_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win_regs[i] <= '0;
      end
    end else if (s1_adv) begin
      win_regs[0] <= win_regs[1];
      win_regs[1] <= upper_rd;
      win_regs[2] <= win_regs[3];
      win_regs[3] <= middle_rd;
      win_regs[4] <= win_regs[5];
      win_regs[5] <= s1_pixel;
    end
  end

  assign win_valid  = s1_valid;
  assign win_flags  = s1_flags;
  assign win.px[0]  = win_regs[0];
  assign win.px[1]  = win_regs[1];
  assign win.px[2]  = upper_rd;
  assign win.px[3]  = win_regs[2];
  assign win.px[4]  = win_regs[3];
  assign win.px[5]  = middle_rd;
  assign win.px[6]  = win_regs[4];
  assign win.px[7]  = win_regs[5];
  assign win.px[8]  = s1_pixel;

endmodule

@@ rtl/prc_gradient.sv @@
// ----------------------------------------------------------------------------
// prc_gradient
// Applies the four compass kernels to a window, then takes the largest
// magnitude, saturates it and holds it in the output register.
// ----------------------------------------------------------------------------
module prc_gradient (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 win_valid,
  input  prc_pkg::window_t     win,
  input  prc_pkg::win_flags_t  win_flags,
  output logic                 win_ready,
  prc_result_if.source         results
);

  prc_pkg::sum_t  sums    [prc_pkg::NUM_DIRS];
  prc_pkg::sum_t  s2_sums [prc_pkg::NUM_DIRS];
  logic           s2_valid;
  logic           s2_last;
  logic           s2_adv;
  logic           s2_load;
  logic           out_free;
  logic [prc_pkg::SUM_W-1:0]    best;
  logic [prc_pkg::PIXEL_W-1:0]  grad_next;

  assign out_free  = !results.valid || results.ready;
  assign s2_adv    = s2_valid && out_free;
  // Border windows give no result and are simply dropped.
  assign win_ready = !win_flags.interior || !s2_valid || out_free;
  assign s2_load   = win_valid && win_ready && win_flags.interior;

  always_comb begin
    prc_pkg::sum_t acc;
    prc_pkg::sum_t ext;
    for (int k = 0; k < prc_pkg::NUM_DIRS; k++) begin
      acc = '0;
      for (int i = 0; i < prc_pkg::WIN_TAPS; i++) begin
        ext = prc_pkg::SUM_W'(win.px[i]);
        if (prc_pkg::KERNEL[k][i] > 0) begin
          acc = acc + ext;
        end else if (prc_pkg::KERNEL[k][i] < 0) begin
          acc = acc - ext;
        end
      end
      sums[k] = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_sums <= sums;
      s2_last <= win_flags.last;
    end
  end

  always_comb begin
    logic [prc_pkg::SUM_W-1:0] mag;
    best = '0;
    for (int k = 0; k < prc_pkg::NUM_DIRS; k++) begin
      mag = s2_sums[k][prc_pkg::SUM_W-1] ? prc_pkg::SUM_W'(-s2_sums[k])
                                          : prc_pkg::SUM_W'(s2_sums[k]);
      if (mag > best) begin
        best = mag;
      end
    end
    if (best > prc_pkg::SUM_W'(prc_pkg::GRAD_MAX)) begin
      grad_next = prc_pkg::PIXEL_W'(prc_pkg::GRAD_MAX);
    end else begin
      grad_next = best[prc_pkg::PIXEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (s2_adv) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      results.gradient      <= grad_next;
      results.last_of_frame <= s2_last;
    end
  end

endmodule

@@ rtl/prewitt_compass_gradient_top.sv @@
// ----------------------------------------------------------------------------
// prewitt_compass_gradient_top
// Streaming 3x3 Prewitt compass edge detector. Grey pixels enter in raster
// order, one per clock at most, and one gradient leaves for every interior
// pixel: the largest magnitude of the 0, 45, 90 and 135 degree kernel sums,
// saturated at 255. The result for a pixel appears after the pixel one row
// below and one column to its right has been taken. Border pixels give no
// result; the consumer fills the border. Each line store is read and written
// once per pixel, which sets the rate at one pixel per clock when nothing
// stalls. Writing line_width or frame_height restarts the frame position;
// the line stores hold no valid state and need no clearing after reset. A
// line_width below 3 acts as 3 and one above MAX_WIDTH as MAX_WIDTH; a
// frame_height below 3 acts as 3.
// ----------------------------------------------------------------------------
module prewitt_compass_gradient_top #(
  parameter int MAX_WIDTH = prc_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [prc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [prc_pkg::CFG_DATA_W-1:0]   cfg_data,
  prc_pixel_if.sink                        pixels,
  prc_result_if.source                     results
);

  logic                 win_valid;
  logic                 win_ready;
  prc_pkg::window_t     win;
  prc_pkg::win_flags_t  win_flags;

  prc_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels),
    .win_valid (win_valid),
    .win       (win),
    .win_flags (win_flags),
    .win_ready (win_ready)
  );

  prc_gradient u_gradient (
    .clk       (clk),
    .rst       (rst),
    .win_valid (win_valid),
    .win       (win),
    .win_flags (win_flags),
    .win_ready (win_ready),
    .results   (results)
  );

  // A window held back by the kernel stage must not change under it.
  assert property (@(posedge clk) disable iff (rst)
    win_valid && !win_ready |=> win_valid && $stable(win) && $stable(win_flags))
    else $error("window changed while stalled");

  // The last pixel of a frame is always interior, since both dimensions are
  // at least three.
  assert property (@(posedge clk) disable iff (rst)
    win_valid && win_flags.last |-> win_flags.interior)
    else $error("frame end flagged on a border pixel");

  // Reset empties the pipeline.
  assert property (@(posedge clk)
    rst |=> !win_valid && !results.valid)
    else $error("pipeline not empty after reset");

endmodule

@@ test/prewitt_compass_gradient_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prewitt_compass_gradient_top_tb
// Self-checking bench for the Prewitt compass gradient block. A local model
// keeps its own line stores, window and frame position, and predicts the
// gradient and end-of-frame flag of every interior pixel. Directed frames
// cover saturation, flat images, clamped and extreme geometries and the
// reset geometry. Random frames, some cut short, follow with bursty input and
// a stalling consumer.
// ----------------------------------------------------------------------------
module prewitt_compass_gradient_top_tb;

  localparam int          RANDOM_ITEMS = 200;
  localparam int          WIDE_ITEMS   = 48;
  localparam int          TALL_ROWS    = 30;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          LONG_HOLD    = 300;
  localparam int          MODEL_DEPTH  = 2048;
  localparam int          PRINT_LIMIT  = 40;

  typedef struct packed {
    logic [prc_pkg::PIXEL_W-1:0] gradient;
    logic                        last;
  } grad_result_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [prc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [prc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  prc_pixel_if  pix_ch ();
  prc_result_if res_ch ();

  prewitt_compass_gradient_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix_ch),
    .results   (res_ch)
  );

  always #10 clk = ~clk;

  // Model state: line stores, window columns, frame position, geometry.
  logic [prc_pkg::PIXEL_W-1:0]    line_upper_q  [MODEL_DEPTH];
  logic [prc_pkg::PIXEL_W-1:0]    line_middle_q [MODEL_DEPTH];
  logic [prc_pkg::PIXEL_W-1:0]    window_q      [6];
  int unsigned                    col_pos;
  int unsigned                    row_pos;
  logic [prc_pkg::CFG_DATA_W-1:0] width_reg;
  logic [prc_pkg::CFG_DATA_W-1:0] height_reg;

  grad_result_t          expected_grads [$];
  int unsigned           mismatches = 0;
  int unsigned           burst_left = 0;

  // Consumer side: a toggle on hold_req starts a long hold-off.
  logic                  hold_req = 1'b0;
  logic                  hold_seen;
  int unsigned           hold_left;
  logic [7:0]            stall_phase;

  function automatic int unsigned eff_width();
    if (width_reg < prc_pkg::MIN_DIM) return prc_pkg::MIN_DIM;
    if (width_reg > MODEL_DEPTH) return MODEL_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg < prc_pkg::MIN_DIM) return prc_pkg::MIN_DIM;
    return height_reg;
  endfunction

  function automatic void predict_gradient(input logic [prc_pkg::PIXEL_W-1:0] px);
    int unsigned  w;
    int unsigned  h;
    int unsigned  c;
    int unsigned  r;
    int           t [9];
    int           s [4];
    int           best;
    grad_result_t res;
    w = eff_width();
    h = eff_height();
    c = (col_pos >= w) ? w - 1 : col_pos;
    r = (row_pos >= h) ? h - 1 : row_pos;
    t[0] = window_q[0]; t[1] = window_q[1]; t[2] = line_upper_q[c];
    t[3] = window_q[2]; t[4] = window_q[3]; t[5] = line_middle_q[c];
    t[6] = window_q[4]; t[7] = window_q[5]; t[8] = px;
    line_upper_q[c]  = line_middle_q[c];
    line_middle_q[c] = px;
    if (r >= 2 && c >= 2) begin
      s[0] = t[0] + t[1] + t[2] - t[6] - t[7] - t[8];
      s[1] = t[0] + t[3] + t[6] - t[2] - t[5] - t[8];
      s[2] = t[0] + t[1] + t[3] - t[5] - t[7] - t[8];
      s[3] = t[1] + t[2] + t[5] - t[3] - t[6] - t[7];
      best = 0;
      foreach (s[k]) begin
        if (s[k] < 0) s[k] = -s[k];
        if (s[k] > best) best = s[k];
      end
      if (best > prc_pkg::GRAD_MAX) best = prc_pkg::GRAD_MAX;
      res.gradient = best[prc_pkg::PIXEL_W-1:0];
      res.last     = (r == h - 1) && (c == w - 1);
      expected_grads.push_back(res);
    end
    window_q[0] = window_q[1]; window_q[1] = t[2];
    window_q[2] = window_q[3]; window_q[3] = t[5];
    window_q[4] = window_q[5]; window_q[5] = px;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    grad_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_grads.size() == 0) begin
        report_mismatch("unexpected result", res_ch.gradient, -1);
      end else begin
        want = expected_grads.pop_front();
        if (res_ch.gradient !== want.gradient)
          report_mismatch("gradient", res_ch.gradient, want.gradient);
        if (res_ch.last_of_frame !== want.last)
          report_mismatch("last_of_frame", res_ch.last_of_frame, want.last);
      end
    end
  end

  // Consumer stalls follow a slowly rotating pattern, broken by long holds.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
      hold_seen    <= 1'b0;
      hold_left    <= 0;
      stall_phase  <= '0;
    end else begin
      stall_phase <= stall_phase + 1'b1;
      if (hold_seen != hold_req) begin
        hold_seen    <= hold_req;
        hold_left    <= LONG_HOLD;
        res_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        res_ch.ready <= 1'b0;
      end else begin
        case (stall_phase[7:6])
          2'd0:    res_ch.ready <= 1'b1;
          2'd1:    res_ch.ready <= ($urandom_range(0, 3) != 0);
          2'd2:    res_ch.ready <= ($urandom_range(0, 3) == 0);
          default: res_ch.ready <= stall_phase[2];
        endcase
      end
    end
  end

  task automatic send_pixel(input logic [prc_pkg::PIXEL_W-1:0] px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    do @(posedge clk); while (!pix_ch.ready);
    predict_gradient(px);
  endtask

  // Stops offering items and waits until every expected result has come.
  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    while (expected_grads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_geometry(input prc_pkg::cfg_reg_t which,
                                input logic [prc_pkg::CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == prc_pkg::REG_LINE_WIDTH) width_reg = value;
    else height_reg = value;
    col_pos = 0;
    row_pos = 0;
    @(posedge clk);
  endtask

  function automatic logic [prc_pkg::PIXEL_W-1:0] pick_pixel(input int unsigned style,
                                                             input int unsigned base);
    case (style)
      1:       return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
      2:       return prc_pkg::PIXEL_W'(base + $urandom_range(0, 7));
      3:       return prc_pkg::PIXEL_W'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 15)
                                                                    : $urandom_range(240, 255));
      default: return prc_pkg::PIXEL_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Power-on geometry: two full rows and the start of a third.
  task automatic test_reset_geometry();
    for (int i = 0; i < 2 * prc_pkg::LINE_WIDTH_RESET + 8; i++)
      send_pixel(prc_pkg::PIXEL_W'($urandom_range(0, 255)));
    drain_results();
  endtask

  task automatic test_small_frames();
    logic [prc_pkg::PIXEL_W-1:0] frame_edge [9] = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0,
                                                    8'd0, 8'd0, 8'd0, 8'd0};
    logic [prc_pkg::PIXEL_W-1:0] frame_ramp [9] = '{8'd10, 8'd20, 8'd30, 8'd40, 8'd50,
                                                    8'd60, 8'd70, 8'd80, 8'd90};
    // Strong horizontal edge saturates at 255.
    write_geometry(prc_pkg::REG_LINE_WIDTH, 12'd3);
    write_geometry(prc_pkg::REG_FRAME_HEIGHT, 12'd3);
    foreach (frame_edge[i]) send_pixel(frame_edge[i]);
    drain_results();
    // Zero geometry acts as three by three; the ramp gives negative sums.
    write_geometry(prc_pkg::REG_LINE_WIDTH, 12'd0);
    write_geometry(prc_pkg::REG_FRAME_HEIGHT, 12'd0);
    foreach (frame_ramp[i]) send_pixel(frame_ramp[i]);
    drain_results();
    // A flat white image has no gradient at all.
    write_geometry(prc_pkg::REG_LINE_WIDTH, 12'd2);
    write_geometry(prc_pkg::REG_FRAME_HEIGHT, 12'd1);
    repeat (9) send_pixel(8'd255);
    drain_results();
  endtask

  // The widest rows are only started, so the stretch stays short.
  task automatic test_wide_lines();
    write_geometry(prc_pkg::REG_LINE_WIDTH, 12'd4095);
    write_geometry(prc_pkg::REG_FRAME_HEIGHT, 12'd3);
    repeat (WIDE_ITEMS) send_pixel(pick_pixel($urandom_range(0, 3), 100));
    drain_results();
    write_geometry(prc_pkg::REG_LINE_WIDTH, 12'd2048);
    repeat (WIDE_ITEMS) send_pixel(pick_pixel($urandom_range(0, 3), 100));
    drain_results();
  endtask

  // The tallest frame is cut short after a few dozen rows.
  task automatic test_tall_frame();
    write_geometry(prc_pkg::REG_LINE_WIDTH, 12'd3);
    write_geometry(prc_pkg::REG_FRAME_HEIGHT, 12'd4095);
    repeat (3 * TALL_ROWS) send_pixel(pick_pixel($urandom_range(0, 3), 60));
    drain_results();
  endtask

  task automatic test_back_pressure();
    write_geometry(prc_pkg::REG_LINE_WIDTH, 12'd8);
    write_geometry(prc_pkg::REG_FRAME_HEIGHT, 12'd6);
    // The consumer holds off while a whole frame is offered without gaps.
    hold_req   <= ~hold_req;
    burst_left = 1000;
    repeat (48) send_pixel(prc_pkg::PIXEL_W'($urandom_range(0, 255)));
    burst_left = 0;
    // The producer pauses mid-frame until everything has drained.
    repeat (20) send_pixel(prc_pkg::PIXEL_W'($urandom_range(0, 255)));
    drain_results();
    repeat (28) send_pixel(prc_pkg::PIXEL_W'($urandom_range(0, 255)));
    drain_results();
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned len;
    int unsigned style;
    int unsigned base;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 2);
        1:       w = $urandom_range(13, 40);
        default: w = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 9))
        0:       h = $urandom_range(0, 2);
        1:       h = $urandom_range(8, 12);
        default: h = $urandom_range(3, 7);
      endcase
      // Sometimes one register or neither is rewritten; when neither is, the
      // position carries on from wherever the previous stretch left it.
      case ($urandom_range(0, 5))
        0:       write_geometry(prc_pkg::REG_LINE_WIDTH, prc_pkg::CFG_DATA_W'(w));
        1:       write_geometry(prc_pkg::REG_FRAME_HEIGHT, prc_pkg::CFG_DATA_W'(h));
        2:       ;
        default: begin
          write_geometry(prc_pkg::REG_LINE_WIDTH, prc_pkg::CFG_DATA_W'(w));
          write_geometry(prc_pkg::REG_FRAME_HEIGHT, prc_pkg::CFG_DATA_W'(h));
        end
      endcase
      if ($urandom_range(0, 4) == 0)
        len = $urandom_range(1, eff_width() * eff_height() - 1);
      else
        len = eff_width() * eff_height() * $urandom_range(1, 2);
      style = $urandom_range(0, 3);
      base  = $urandom_range(0, 248);
      for (int i = 0; i < len; i++) begin
        send_pixel(pick_pixel(style, base));
        sent++;
        if ($urandom_range(0, 299) == 0) drain_results();
        if ($urandom_range(0, 499) == 0) hold_req <= ~hold_req;
      end
      drain_results();
    end
  endtask

  initial begin
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    foreach (line_upper_q[i]) begin
      line_upper_q[i]  = '0;
      line_middle_q[i] = '0;
    end
    foreach (window_q[i]) window_q[i] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = prc_pkg::CFG_DATA_W'(prc_pkg::LINE_WIDTH_RESET);
    height_reg = prc_pkg::CFG_DATA_W'(prc_pkg::FRAME_HEIGHT_RESET);
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_geometry();
    test_small_frames();
    test_back_pressure();
    test_wide_lines();
    test_tall_frame();
    test_random_frames();
    drain_results();

    if (mismatches == 0 && expected_grads.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
